// ===== sv/dcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadzone curve mapper package
// Widths of the channel payloads, the configuration port and the shared
// shift-add multiplier.
// ----------------------------------------------------------------------------
package dcm_pkg;

	// Raw sample and configuration register widths.
	localparam int SAMPLE_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 3;

	// Conditioned output, signed Q8.16.
	localparam int OUT_W = 25;

	// Serial multiplier: multiplicand, multiplier (one bit per cycle), product.
	localparam int MUL_A_W   = 34;
	localparam int MUL_B_W   = 17;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int MUL_CNT_W = $clog2(MUL_B_W);

endpackage

// ===== sv/dcm_in_if.sv =====
// ----------------------------------------------------------------------------
// Sample channel
// Valid/ready channel carrying one raw axis sample per transfer.
// ----------------------------------------------------------------------------
interface dcm_in_if;

	logic                          valid;
	logic                          ready;
	logic [dcm_pkg::SAMPLE_W-1:0]  raw_sample;

	modport source (output valid, output raw_sample, input ready);
	modport sink (input valid, input raw_sample, output ready);

endinterface

// ===== sv/dcm_out_if.sv =====
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one conditioned axis value and its moved flag.
// ----------------------------------------------------------------------------
interface dcm_out_if;

	logic                              valid;
	logic                              ready;
	logic signed [dcm_pkg::OUT_W-1:0]  axis_out;
	logic                              moved;

	modport source (output valid, output axis_out, output moved, input ready);
	modport sink (input valid, input axis_out, input moved, output ready);

endinterface

// ===== sv/dcm_mul.sv =====
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned product of a and b, taking one bit of b per cycle, LSB first.
// The result is valid in the cycle in which done is high and holds until the
// next start.
// ----------------------------------------------------------------------------
module dcm_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [dcm_pkg::MUL_A_W-1:0]  a,
	input  logic [dcm_pkg::MUL_B_W-1:0]  b,
	output logic                         done,
	output logic [dcm_pkg::MUL_P_W-1:0]  p
);

	logic                           busy_q;
	logic                           done_q;
	logic [dcm_pkg::MUL_CNT_W-1:0]  cnt_q;
	logic [dcm_pkg::MUL_A_W-1:0]    a_q;
	logic [dcm_pkg::MUL_P_W-1:0]    p_q;
	logic [dcm_pkg::MUL_A_W:0]      acc;
	logic                           last_step;

	// The upper half accumulates while the multiplier bits shift out at the bottom.
	assign acc = {1'b0, p_q[dcm_pkg::MUL_P_W-1:dcm_pkg::MUL_B_W]}
		+ (p_q[0] ? {1'b0, a_q} : '0);
	assign last_step = (cnt_q == dcm_pkg::MUL_CNT_W'(dcm_pkg::MUL_B_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + 1'b1;
			busy_q <= !last_step;
			done_q <= last_step;
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			p_q <= {{dcm_pkg::MUL_A_W{1'b0}}, b};
		end else if (busy_q) begin
			p_q <= {acc, p_q[dcm_pkg::MUL_B_W-1:1]};
		end
	end

	assign done = done_q;
	assign p    = p_q;

endmodule

// ===== sv/axis_deadzone_curve_mapper.sv =====
// ----------------------------------------------------------------------------
// Axis deadzone and response curve mapper
// Clamps a raw axis sample to its outer bounds, maps it piecewise linearly
// around the null zone, applies inversion, sign conversion and a cubic
// response curve, scales it by the gain and flags movement past a threshold.
//
//   Channel     Modport   Payload
//   sample_ch   sink      raw_sample  (16 bit unsigned Q0.16)
//   result_ch   source    axis_out    (25 bit signed Q8.16), moved
//   cfg_*       input     cfg_wr_en, cfg_index, cfg_wdata (write only)
//
// One item is in work at a time, and the serial multiplier sets the pace.
// The next sample is taken while the previous result still waits in the
// output register. Reset clears the registers to their defaults and the
// last reported value to zero.
// ----------------------------------------------------------------------------
module axis_deadzone_curve_mapper (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wr_en,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dcm_pkg::CFG_W-1:0]       cfg_wdata,
	dcm_in_if.sink                          sample_ch,
	dcm_out_if.source                       result_ch
);

	typedef enum logic [13:0] {
		ST_IDLE  = 14'b00000000000001,
		ST_MAP   = 14'b00000000000010,
		ST_DIV   = 14'b00000000000100,
		ST_PRE   = 14'b00000000001000,
		ST_SQ    = 14'b00000000010000,
		ST_CU    = 14'b00000000100000,
		ST_T1    = 14'b00000001000000,
		ST_T2    = 14'b00000010000000,
		ST_BLEND = 14'b00000100000000,
		ST_POST  = 14'b00001000000000,
		ST_SCALE = 14'b00010000000000,
		ST_THR   = 14'b00100000000000,
		ST_CMP   = 14'b01000000000000,
		ST_DONE  = 14'b10000000000000
	} state_t;

	localparam logic [13:0] MUL_STATES = ST_SQ | ST_CU | ST_T1 | ST_T2 | ST_SCALE | ST_THR;

	localparam logic [2:0] REG_BOUND_LOWER = 3'd0;
	localparam logic [2:0] REG_BOUND_UPPER = 3'd1;
	localparam logic [2:0] REG_NULL_LOWER  = 3'd2;
	localparam logic [2:0] REG_NULL_UPPER  = 3'd3;
	localparam logic [2:0] REG_CURVE       = 3'd4;
	localparam logic [2:0] REG_GAIN        = 3'd5;
	localparam logic [2:0] REG_DELTA       = 3'd6;
	localparam logic [2:0] REG_MODE        = 3'd7;

	localparam logic [1:0] SGN_PRE  = 2'd1;
	localparam logic [1:0] SGN_POST = 2'd2;

	localparam logic [3:0] DIV_LAST = 4'd14;

	// Configuration and reported state
	logic [15:0]         bound_lower_q;
	logic [15:0]         bound_upper_q;
	logic [15:0]         null_lower_q;
	logic [15:0]         null_upper_q;
	logic signed [15:0]  curve_q;
	logic [15:0]         gain_q;
	logic [15:0]         delta_q;
	logic [2:0]          mode_q;
	logic signed [24:0]  last_q;

	// Control
	state_t              state_q;
	state_t              state_d;
	logic                mul_go_q;
	logic                out_valid_q;
	logic                in_fire;
	logic                out_free;
	logic [1:0]          sign_mode;

	// Datapath registers
	logic [15:0]         x_q;
	logic [15:0]         rem_q;
	logic [15:0]         den_q;
	logic [14:0]         q_q;
	logic [3:0]          div_cnt_q;
	logic                off_q;
	logic [16:0]         m_q;
	logic signed [18:0]  v_q;
	logic [16:0]         cube_q;
	logic [31:0]         t1_q;
	logic signed [33:0]  s_q;
	logic signed [24:0]  res_q;
	logic [31:0]         thr_q;
	logic signed [25:0]  d_q;
	logic                moved_q;
	logic signed [24:0]  axis_out_q;
	logic                moved_out_q;

	// Multiplier
	logic [dcm_pkg::MUL_A_W-1:0]  mul_a;
	logic [dcm_pkg::MUL_B_W-1:0]  mul_b;
	logic                         mul_done;
	logic [dcm_pkg::MUL_P_W-1:0]  mul_p;

	// Combinational terms
	logic                lower;
	logic [15:0]         xl;
	logic [15:0]         num_l;
	logic [15:0]         den_l;
	logic [15:0]         xu;
	logic [15:0]         num_u;
	logic [15:0]         den_u;
	logic                map_div;
	logic [16:0]         m_map;
	logic [16:0]         rem_sh;
	logic [16:0]         rem_sub;
	logic                div_ge;
	logic [15:0]         rem_n;
	logic [14:0]         q_n;
	logic [16:0]         m_div;
	logic [16:0]         inv;
	logic signed [18:0]  v_ext;
	logic signed [18:0]  v_pre;
	logic                v_neg;
	logic signed [18:0]  v_abs;
	logic [17:0]         v_mag;
	logic                c_neg;
	logic signed [15:0]  c_abs;
	logic [14:0]         c_mag;
	logic signed [16:0]  c_comp;
	logic signed [33:0]  t1_ext;
	logic signed [33:0]  t2_ext;
	logic signed [33:0]  blend_sum;
	logic signed [33:0]  s_abs;
	logic [19:0]         blend_mag;
	logic [16:0]         blend_clamp;
	logic signed [18:0]  blend_ext;
	logic signed [18:0]  v_blend;
	logic signed [18:0]  v_post;
	logic [25:0]         scl;
	logic [23:0]         scl_sat;
	logic signed [24:0]  scl_ext;
	logic signed [24:0]  res_n;
	logic signed [25:0]  diff_n;
	logic signed [25:0]  d_abs;
	logic                moved_n;

	assign sample_ch.ready = (state_q == ST_IDLE);
	assign in_fire   = sample_ch.valid && sample_ch.ready;
	assign out_free  = !out_valid_q || result_ch.ready;
	assign sign_mode = mode_q[2:1];

	assign result_ch.valid    = out_valid_q;
	assign result_ch.axis_out = axis_out_q;
	assign result_ch.moved    = moved_out_q;

	// Piecewise map: clamp to the outer bound, then set up the half-range division.
	always_comb begin
		lower = (x_q < null_lower_q);
		xl    = (x_q < bound_lower_q) ? bound_lower_q : x_q;
		num_l = xl - bound_lower_q;
		den_l = null_lower_q - bound_lower_q;
		xu    = (x_q > bound_upper_q) ? bound_upper_q : x_q;
		num_u = xu - null_upper_q;
		den_u = bound_upper_q - null_upper_q;
		if (lower) begin
			map_div = (null_lower_q > bound_lower_q);
			m_map   = 17'd0;
		end else begin
			map_div = (x_q > null_upper_q) && (bound_upper_q > null_upper_q)
				&& (num_u != den_u);
			// A full-range upper term or a reversed upper bound lands on one.
			if ((x_q > null_upper_q) && ((bound_upper_q < null_upper_q)
				|| ((bound_upper_q > null_upper_q) && (num_u == den_u)))) begin
				m_map = 17'h10000;
			end else begin
				m_map = 17'h08000;
			end
		end
	end

	// One quotient bit per cycle; the remainder stays below the divisor.
	always_comb begin
		rem_sh  = {rem_q, 1'b0};
		rem_sub = rem_sh - {1'b0, den_q};
		div_ge  = (rem_sh >= {1'b0, den_q});
		rem_n   = div_ge ? rem_sub[15:0] : rem_sh[15:0];
		q_n     = {q_q[13:0], div_ge};
		m_div   = off_q ? (17'h08000 + {2'b00, q_n}) : {2'b00, q_n};
	end

	always_comb begin
		inv   = mode_q[0] ? (17'h10000 - m_q) : m_q;
		v_ext = $signed({2'b00, inv});
		v_pre = (sign_mode == SGN_PRE) ? ((v_ext <<< 1) - 19'sd65536) : v_ext;

		v_neg = v_q[18];
		v_abs = v_neg ? -v_q : v_q;
		v_mag = v_abs[17:0];

		c_neg  = curve_q[15];
		c_abs  = c_neg ? -curve_q : curve_q;
		c_mag  = c_abs[14:0];
		c_comp = 17'sd16384 - {curve_q[15], curve_q};

		// Both blend terms carry their sign before the sum is truncated.
		t1_ext    = $signed({2'b00, t1_q});
		t2_ext    = $signed({2'b00, mul_p[31:0]});
		blend_sum = (v_neg ? -t1_ext : t1_ext) + ((v_neg ^ c_neg) ? -t2_ext : t2_ext);

		s_abs       = s_q[33] ? -s_q : s_q;
		blend_mag   = s_abs[33:14];
		blend_clamp = (blend_mag > 20'd65536) ? 17'h10000 : blend_mag[16:0];
		blend_ext   = $signed({2'b00, blend_clamp});
		v_blend     = s_q[33] ? -blend_ext : blend_ext;

		v_post = (sign_mode == SGN_POST) ? ((v_q <<< 1) - 19'sd65536) : v_q;

		scl     = mul_p[33:8];
		scl_sat = (scl > 26'd16777215) ? 24'hFFFFFF : scl[23:0];
		scl_ext = $signed({1'b0, scl_sat});
		res_n   = v_neg ? -scl_ext : scl_ext;

		diff_n  = {res_q[24], res_q} - {last_q[24], last_q};
		d_abs   = d_q[25] ? -d_q : d_q;
		moved_n = ({d_abs[24:0], 8'h00} >= {1'b0, thr_q});
	end

	always_comb begin
		unique case (state_q)
			ST_SQ: begin
				mul_a = dcm_pkg::MUL_A_W'(v_mag);
				mul_b = dcm_pkg::MUL_B_W'(v_mag);
			end
			ST_CU: begin
				mul_a = mul_p[dcm_pkg::MUL_A_W-1:0];
				mul_b = dcm_pkg::MUL_B_W'(v_mag);
			end
			ST_T1: begin
				mul_a = dcm_pkg::MUL_A_W'(v_mag);
				mul_b = c_comp[dcm_pkg::MUL_B_W-1:0];
			end
			ST_T2: begin
				mul_a = dcm_pkg::MUL_A_W'(cube_q);
				mul_b = dcm_pkg::MUL_B_W'(c_mag);
			end
			ST_SCALE: begin
				mul_a = dcm_pkg::MUL_A_W'(v_mag);
				mul_b = dcm_pkg::MUL_B_W'(gain_q);
			end
			ST_THR: begin
				mul_a = dcm_pkg::MUL_A_W'(delta_q);
				mul_b = dcm_pkg::MUL_B_W'(gain_q);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	dcm_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_go_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (mul_p)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_fire) state_d = ST_MAP;
			ST_MAP:   state_d = map_div ? ST_DIV : ST_PRE;
			ST_DIV:   if (div_cnt_q == DIV_LAST) state_d = ST_PRE;
			ST_PRE:   state_d = (curve_q != 16'sd0) ? ST_SQ : ST_POST;
			ST_SQ:    if (mul_done) state_d = ST_CU;
			ST_CU:    if (mul_done) state_d = ST_T1;
			ST_T1:    if (mul_done) state_d = ST_T2;
			ST_T2:    if (mul_done) state_d = ST_BLEND;
			ST_BLEND: state_d = ST_POST;
			ST_POST:  state_d = ST_SCALE;
			ST_SCALE: if (mul_done) state_d = ST_THR;
			ST_THR:   if (mul_done) state_d = ST_CMP;
			ST_CMP:   state_d = ST_DONE;
			ST_DONE:  if (out_free) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			mul_go_q      <= 1'b0;
			out_valid_q   <= 1'b0;
			bound_lower_q <= 16'd0;
			bound_upper_q <= 16'd65535;
			null_lower_q  <= 16'd32768;
			null_upper_q  <= 16'd32768;
			curve_q       <= 16'sd0;
			gain_q        <= 16'd256;
			delta_q       <= 16'd0;
			mode_q        <= 3'd0;
			last_q        <= 25'sd0;
		end else begin
			state_q  <= state_d;
			// Each multiplier state starts its product on entry.
			mul_go_q <= (state_d != state_q) && ((state_d & MUL_STATES) != 14'd0);

			if ((state_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
				if (moved_q) begin
					last_q <= res_q;
				end
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_BOUND_LOWER: bound_lower_q <= cfg_wdata;
					REG_BOUND_UPPER: bound_upper_q <= cfg_wdata;
					REG_NULL_LOWER:  null_lower_q  <= cfg_wdata;
					REG_NULL_UPPER:  null_upper_q  <= cfg_wdata;
					REG_CURVE: begin
						if ($signed(cfg_wdata) > 16'sd16384) begin
							curve_q <= 16'sd16384;
						end else if ($signed(cfg_wdata) < -16'sd16384) begin
							curve_q <= -16'sd16384;
						end else begin
							curve_q <= $signed(cfg_wdata);
						end
					end
					REG_GAIN:        gain_q  <= cfg_wdata;
					REG_DELTA:       delta_q <= cfg_wdata;
					REG_MODE:        mode_q  <= cfg_wdata[2:0];
					default:         mode_q  <= mode_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					x_q <= sample_ch.raw_sample;
				end
			end
			ST_MAP: begin
				rem_q     <= lower ? num_l : num_u;
				den_q     <= lower ? den_l : den_u;
				off_q     <= !lower;
				q_q       <= '0;
				div_cnt_q <= '0;
				m_q       <= m_map;
			end
			ST_DIV: begin
				rem_q     <= rem_n;
				q_q       <= q_n;
				div_cnt_q <= div_cnt_q + 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					m_q <= m_div;
				end
			end
			ST_PRE: v_q <= v_pre;
			ST_SQ: begin
			end
			ST_CU: begin
				if (mul_done) begin
					cube_q <= mul_p[48:32];
				end
			end
			ST_T1: begin
				if (mul_done) begin
					t1_q <= mul_p[31:0];
				end
			end
			ST_T2: begin
				if (mul_done) begin
					s_q <= blend_sum;
				end
			end
			ST_BLEND: v_q <= v_blend;
			ST_POST:  v_q <= v_post;
			ST_SCALE: begin
				if (mul_done) begin
					res_q <= res_n;
				end
			end
			ST_THR: begin
				if (mul_done) begin
					thr_q <= mul_p[31:0];
					d_q   <= diff_n;
				end
			end
			ST_CMP: moved_q <= moved_n;
			ST_DONE: begin
				if (out_free) begin
					axis_out_q  <= res_q;
					moved_out_q <= moved_q;
				end
			end
			default: begin
			end
		endcase
	end

	// A transfer in always starts the map in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == ST_MAP))
		else $error("sample transfer did not start the map");

	// The long division keeps its partial remainder below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < den_q))
		else $error("divider remainder reached the divisor");

	// A new result appears only from the final state.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_DONE))
		else $error("result became valid outside the final state");

	// The reported value only follows a result that moved.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && out_free && !moved_q) |=> $stable(last_q))
		else $error("last reported value changed without movement");

endmodule

// ===== test/dcm_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// Deadzone curve mapper testbench definitions
// Register indexes and mode encodings shared by the stimulus and the checker.
// ----------------------------------------------------------------------------
package dcm_tb_pkg;

	typedef enum logic [2:0] {
		REG_BOUND_LOWER    = 3'd0,
		REG_BOUND_UPPER    = 3'd1,
		REG_NULL_LOWER     = 3'd2,
		REG_NULL_UPPER     = 3'd3,
		REG_CURVE_FACTOR   = 3'd4,
		REG_GAIN           = 3'd5,
		REG_DELTA_FRACTION = 3'd6,
		REG_MODE_FLAGS     = 3'd7
	} reg_index_t;

	localparam int REG_COUNT = 8;

	typedef enum logic [1:0] {
		SIGN_NONE     = 2'd0,
		SIGN_PRE      = 2'd1,
		SIGN_POST     = 2'd2,
		SIGN_RESERVED = 2'd3
	} sign_mode_t;

	localparam int MODE_INVERT_BIT = 0;

	// Unity of the curve factor, Q1.14.
	localparam int CURVE_ONE = 16384;

	function automatic logic [2:0] mode_word(logic invert, sign_mode_t sign);
		return {sign, invert};
	endfunction

endpackage

// ===== test/dcm_result_checker.sv =====
// ----------------------------------------------------------------------------
// Deadzone curve mapper result checker
// Follows the configuration port, predicts the conditioned axis value and
// moved flag for every accepted sample, and compares each result transfer
// in order against the oldest prediction.
// ----------------------------------------------------------------------------
module dcm_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [dcm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dcm_pkg::CFG_W-1:0]      cfg_wdata,
	dcm_in_if                              sample_ch,
	dcm_out_if                             result_ch,
	output int                             fail_count,
	output int                             pending_results,
	output int                             checked_count,
	output int                             moved_count
);

	timeunit 1ns;
	timeprecision 1ps;

	import dcm_pkg::*;
	import dcm_tb_pkg::*;

	localparam longint ONE_Q16   = 65536;
	localparam longint HALF_Q16  = 32768;
	localparam longint OUT_LIMIT = 16777215;

	typedef struct packed {
		logic signed [OUT_W-1:0] axis;
		logic                    moved;
	} axis_expect_t;

	axis_expect_t expected_axis[$];

	longint     bound_lo, bound_hi, null_lo, null_hi;
	longint     curve_q, gain_q, delta_q;
	logic [2:0] mode_q;
	longint     last_axis;

	function automatic longint toward_zero_shift(longint v, int sh);
		if (v < 0)
			return -((-v) >> sh);
		return v >> sh;
	endfunction

	// Piecewise map onto 0..1 in Q.16, the whole null zone giving one half.
	function automatic longint map_position(longint x);
		longint v;
		longint den;
		if (x < null_lo) begin
			v = (x < bound_lo) ? bound_lo : x;
			den = null_lo - bound_lo;
			if (den <= 0)
				return 0;
			return (v - bound_lo) * HALF_Q16 / den;
		end
		if (x <= null_hi)
			return HALF_Q16;
		v = (x > bound_hi) ? bound_hi : x;
		den = bound_hi - null_hi;
		if (den == 0)
			return HALF_Q16;
		if (den < 0)
			return ONE_Q16;
		return HALF_Q16 + (v - null_hi) * HALF_Q16 / den;
	endfunction

	function automatic axis_expect_t predict_axis(logic [SAMPLE_W-1:0] raw);
		longint       pos;
		longint       cube;
		longint       scaled;
		longint       diff;
		sign_mode_t   sign;
		axis_expect_t res;
		sign = sign_mode_t'(mode_q[2:1]);
		pos = map_position(longint'(raw));
		if (mode_q[MODE_INVERT_BIT])
			pos = ONE_Q16 - pos;
		if (sign == SIGN_PRE)
			pos = 2 * pos - ONE_Q16;
		if (curve_q != 0) begin
			cube = toward_zero_shift(pos * pos * pos, 32);
			pos = toward_zero_shift(pos * (CURVE_ONE - curve_q) + curve_q * cube, 14);
			if (pos > ONE_Q16)
				pos = ONE_Q16;
			if (pos < -ONE_Q16)
				pos = -ONE_Q16;
		end
		if (sign == SIGN_POST)
			pos = 2 * pos - ONE_Q16;
		scaled = toward_zero_shift(pos * gain_q, 8);
		if (scaled > OUT_LIMIT)
			scaled = OUT_LIMIT;
		if (scaled < -OUT_LIMIT)
			scaled = -OUT_LIMIT;
		diff = scaled - last_axis;
		if (diff < 0)
			diff = -diff;
		res.axis = scaled[OUT_W-1:0];
		res.moved = (diff * 256 >= delta_q * gain_q);
		// The reference point only follows values that were reported as moved.
		if (res.moved)
			last_axis = scaled;
		return res;
	endfunction

	task automatic apply_write(reg_index_t idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_BOUND_LOWER: bound_lo = longint'(data);
			REG_BOUND_UPPER: bound_hi = longint'(data);
			REG_NULL_LOWER: null_lo = longint'(data);
			REG_NULL_UPPER: null_hi = longint'(data);
			REG_CURVE_FACTOR: begin
				curve_q = longint'($signed(data));
				if (curve_q > CURVE_ONE)
					curve_q = CURVE_ONE;
				if (curve_q < -CURVE_ONE)
					curve_q = -CURVE_ONE;
			end
			REG_GAIN: gain_q = longint'(data);
			REG_DELTA_FRACTION: delta_q = longint'(data);
			REG_MODE_FLAGS: mode_q = data[2:0];
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		axis_expect_t want;
		if (!arst_n) begin
			bound_lo = 0;
			bound_hi = 65535;
			null_lo = 32768;
			null_hi = 32768;
			curve_q = 0;
			gain_q = 256;
			delta_q = 0;
			mode_q = '0;
			last_axis = 0;
			expected_axis.delete();
			fail_count = 0;
			pending_results = 0;
			checked_count = 0;
			moved_count = 0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (expected_axis.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with nothing expected: axis_out %0d moved %0b",
						$time, result_ch.axis_out, result_ch.moved);
				end else begin
					want = expected_axis.pop_front();
					if (result_ch.axis_out !== want.axis) begin
						fail_count++;
						$display("%0t ns: axis_out expected %0d, actual %0d",
							$time, $signed(want.axis), result_ch.axis_out);
					end
					if (result_ch.moved !== want.moved) begin
						fail_count++;
						$display("%0t ns: moved expected %0b, actual %0b",
							$time, want.moved, result_ch.moved);
					end
					checked_count++;
					if (want.moved)
						moved_count++;
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				expected_axis.push_back(predict_axis(sample_ch.raw_sample));
			if (cfg_wr_en)
				apply_write(reg_index_t'(cfg_index), cfg_wdata);
			pending_results = expected_axis.size();
		end
	end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Deadzone curve mapper testbench
// Drives a directed set of samples through the reset settings and the corner
// configurations, then random register settings with random samples, with
// bursty sample traffic and a stalling result receiver. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import dcm_pkg::*;
	import dcm_tb_pkg::*;

	localparam int RANDOM_SAMPLES = 1400;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_W-1:0]      cfg_wdata;

	int fail_count;
	int pending_results;
	int checked_count;
	int moved_count;

	int samples_sent;
	int settings_used;

	logic [CFG_W-1:0]    next_cfg [REG_COUNT];
	logic [SAMPLE_W-1:0] sample_plan[$];

	dcm_in_if  sample_if ();
	dcm_out_if result_if ();

	axis_deadzone_curve_mapper DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample_ch (sample_if),
		.result_ch (result_if)
	);

	dcm_result_checker u_result_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.sample_ch       (sample_if),
		.result_ch       (result_if),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.checked_count   (checked_count),
		.moved_count     (moved_count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Timed out with %0d results still outstanding.", pending_results);
		$display("== FAIL ==");
		$finish;
	end

	// Receiver: switches at random between stall styles.
	initial begin
		int stall_left;
		int style;
		int style_left;
		stall_left = 0;
		style = 0;
		style_left = 0;
		result_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (style_left == 0) begin
				style = $urandom_range(0, 3);
				style_left = $urandom_range(200, 2000);
			end
			style_left--;
			if (stall_left > 0) begin
				stall_left--;
				result_if.ready <= 1'b0;
			end else if (style == 1 && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 3);
				result_if.ready <= 1'b0;
			end else if (style == 2 && $urandom_range(0, 15) == 0) begin
				stall_left = $urandom_range(4, 24);
				result_if.ready <= 1'b0;
			end else if (style == 3) begin
				result_if.ready <= ($urandom_range(0, 3) == 0);
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	task automatic load_defaults();
		next_cfg[REG_BOUND_LOWER] = 16'd0;
		next_cfg[REG_BOUND_UPPER] = 16'd65535;
		next_cfg[REG_NULL_LOWER] = 16'd32768;
		next_cfg[REG_NULL_UPPER] = 16'd32768;
		next_cfg[REG_CURVE_FACTOR] = 16'd0;
		next_cfg[REG_GAIN] = 16'd256;
		next_cfg[REG_DELTA_FRACTION] = 16'd0;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b0, SIGN_NONE)};
	endtask

	// Back-to-back register writes; the enable stays high until the last one.
	task automatic write_config();
		for (int i = 0; i < REG_COUNT; i++) begin
			@(posedge clk);
			cfg_wr_en <= 1'b1;
			cfg_index <= reg_index_t'(i);
			cfg_wdata <= next_cfg[i];
		end
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Sends the planned samples in bursts, then waits for every result.
	task automatic play_and_drain();
		int burst;
		int gap;
		while (sample_plan.size() > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && sample_plan.size() > 0) begin
				sample_if.valid <= 1'b1;
				sample_if.raw_sample <= sample_plan.pop_front();
				@(posedge clk);
				while (!sample_if.ready)
					@(posedge clk);
				burst--;
				samples_sent++;
			end
			case ($urandom_range(0, 2))
				0: gap = 0;
				1: gap = $urandom_range(1, 40);
				default: gap = $urandom_range(41, 180);
			endcase
			if (gap > 0 || sample_plan.size() == 0) begin
				sample_if.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [CFG_W-1:0] anchor;
		case ($urandom_range(0, 9))
			5, 6: begin
				case ($urandom_range(0, 3))
					0: anchor = next_cfg[REG_BOUND_LOWER];
					1: anchor = next_cfg[REG_BOUND_UPPER];
					2: anchor = next_cfg[REG_NULL_LOWER];
					default: anchor = next_cfg[REG_NULL_UPPER];
				endcase
				return SAMPLE_W'(int'(anchor) + int'($urandom_range(0, 6)) - 3);
			end
			7: begin
				if (next_cfg[REG_NULL_LOWER] <= next_cfg[REG_NULL_UPPER])
					return SAMPLE_W'($urandom_range(next_cfg[REG_NULL_LOWER],
						next_cfg[REG_NULL_UPPER]));
				return SAMPLE_W'($urandom);
			end
			8: return ($urandom_range(0, 1) == 0) ? '0 : '1;
			default: return SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic randomise_config();
		int unsigned bl;
		int unsigned nl;
		int unsigned nu;
		int unsigned bu;
		// Mostly ordered bounds around the null zone; the rest anything at all.
		if ($urandom_range(0, 3) != 0) begin
			bl = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 20000);
			nl = $urandom_range(bl + 1, 40000);
			nu = ($urandom_range(0, 3) == 0) ? nl : $urandom_range(nl, 45000);
			bu = ($urandom_range(0, 4) == 0) ? 65535 : $urandom_range(nu + 1, 65535);
		end else begin
			bl = $urandom_range(0, 65535);
			nl = $urandom_range(0, 65535);
			nu = $urandom_range(0, 65535);
			bu = $urandom_range(0, 65535);
		end
		next_cfg[REG_BOUND_LOWER] = CFG_W'(bl);
		next_cfg[REG_BOUND_UPPER] = CFG_W'(bu);
		next_cfg[REG_NULL_LOWER] = CFG_W'(nl);
		next_cfg[REG_NULL_UPPER] = CFG_W'(nu);
		case ($urandom_range(0, 5))
			0: next_cfg[REG_CURVE_FACTOR] = '0;
			1: next_cfg[REG_CURVE_FACTOR] = CFG_W'(CURVE_ONE);
			2: next_cfg[REG_CURVE_FACTOR] = CFG_W'(-CURVE_ONE);
			5: next_cfg[REG_CURVE_FACTOR] = CFG_W'($urandom);
			default: next_cfg[REG_CURVE_FACTOR] =
				CFG_W'(int'($urandom_range(0, 2 * CURVE_ONE)) - CURVE_ONE);
		endcase
		case ($urandom_range(0, 7))
			0: next_cfg[REG_GAIN] = '0;
			1: next_cfg[REG_GAIN] = '1;
			2: next_cfg[REG_GAIN] = CFG_W'(1);
			3: next_cfg[REG_GAIN] = CFG_W'($urandom_range(1, 65535));
			default: next_cfg[REG_GAIN] = CFG_W'($urandom_range(1, 2048));
		endcase
		case ($urandom_range(0, 5))
			0: next_cfg[REG_DELTA_FRACTION] = '0;
			1: next_cfg[REG_DELTA_FRACTION] = '1;
			2: next_cfg[REG_DELTA_FRACTION] = CFG_W'($urandom);
			default: next_cfg[REG_DELTA_FRACTION] = CFG_W'($urandom_range(0, 8192));
		endcase
		next_cfg[REG_MODE_FLAGS] = CFG_W'($urandom_range(0, 7));
	endtask

	initial begin
		int random_left;
		int count;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		sample_if.valid <= 1'b0;
		sample_if.raw_sample <= '0;
		samples_sent = 0;
		settings_used = 1;
		load_defaults();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, no writes.
		sample_plan = '{16'd0, 16'd65535, 16'd32768, 16'd32767, 16'd32769};
		play_and_drain();

		// Both denominators zero, inverted, largest gain and threshold.
		load_defaults();
		next_cfg[REG_BOUND_LOWER] = 16'd20000;
		next_cfg[REG_NULL_LOWER] = 16'd20000;
		next_cfg[REG_NULL_UPPER] = 16'd40000;
		next_cfg[REG_BOUND_UPPER] = 16'd40000;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b1, SIGN_NONE)};
		next_cfg[REG_GAIN] = 16'd65535;
		next_cfg[REG_DELTA_FRACTION] = 16'd65535;
		write_config();
		sample_plan = '{16'd100, 16'd30000, 16'd65535, 16'd0};
		play_and_drain();

		// Upper bound below a reversed null zone, curve above one, sign before.
		load_defaults();
		next_cfg[REG_BOUND_LOWER] = 16'd1000;
		next_cfg[REG_BOUND_UPPER] = 16'd10000;
		next_cfg[REG_NULL_LOWER] = 16'd40000;
		next_cfg[REG_NULL_UPPER] = 16'd30000;
		next_cfg[REG_CURVE_FACTOR] = 16'h7fff;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b0, SIGN_PRE)};
		write_config();
		sample_plan = '{16'd35000, 16'd45000, 16'd500};
		play_and_drain();

		// Reserved sign mode with inversion, curve below minus one, gain zero.
		load_defaults();
		next_cfg[REG_CURVE_FACTOR] = 16'h8000;
		next_cfg[REG_GAIN] = 16'd0;
		next_cfg[REG_DELTA_FRACTION] = 16'd4660;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b1, SIGN_RESERVED)};
		write_config();
		sample_plan = '{16'd0, 16'd65535, 16'd12345};
		play_and_drain();

		// Full positive curve with the sign applied after it.
		load_defaults();
		next_cfg[REG_CURVE_FACTOR] = CFG_W'(CURVE_ONE);
		next_cfg[REG_GAIN] = 16'd65535;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b0, SIGN_POST)};
		write_config();
		sample_plan = '{16'd0, 16'd65535, 16'd16384, 16'd49152};
		play_and_drain();

		// Lower bound above the null zone, full negative curve, smallest non-zero gain.
		load_defaults();
		next_cfg[REG_BOUND_LOWER] = 16'd50000;
		next_cfg[REG_CURVE_FACTOR] = CFG_W'(-CURVE_ONE);
		next_cfg[REG_GAIN] = 16'd1;
		next_cfg[REG_MODE_FLAGS] = {13'd0, mode_word(1'b0, SIGN_PRE)};
		write_config();
		sample_plan = '{16'd40000, 16'd10000, 16'd60000};
		play_and_drain();

		random_left = RANDOM_SAMPLES;
		while (random_left > 0) begin
			randomise_config();
			write_config();
			count = $urandom_range(15, 70);
			if (count > random_left)
				count = random_left;
			repeat (count) sample_plan.push_back(pick_sample());
			play_and_drain();
			random_left -= count;
		end

		repeat (150) @(posedge clk);
		$display("Sent %0d samples under %0d register settings.", samples_sent, settings_used);
		$display("Compared %0d results, %0d of them flagged as moved.",
			checked_count, moved_count);
		if (fail_count == 0 && pending_results == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

// ===== files.f =====
sv/dcm_pkg.sv
sv/dcm_in_if.sv
sv/dcm_out_if.sv
sv/dcm_mul.sv
sv/axis_deadzone_curve_mapper.sv
test/dcm_tb_pkg.sv
test/dcm_result_checker.sv
test/tb_top.sv
